@@ hw/rtl/fnas_pkg.sv @@
// Package: constants and types shared by the fire neighbour average blocks.
package fnas_pkg;

  localparam int LINE_WIDTH = 320;
  localparam int LINE_DEPTH = 2 * LINE_WIDTH + 2;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = PIX_W + 3;
  localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
  localparam int PTR_W      = $clog2(LINE_WIDTH);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_HEADROOM = FIFO_DEPTH - 2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic valid;
    pix_t average;
    logic last_of_page;
  } res_t;

endpackage

@@ hw/rtl/fnas_in_if.sv @@
// Interface: input pixel channel.
interface fnas_in_if;
  logic                  valid;
  logic                  ready;
  logic [fnas_pkg::PIX_W-1:0] pixel;
  logic                  frame_start;
  logic                  frame_end;

  modport source (output valid, output pixel, output frame_start, output frame_end,
                  input ready);
  modport sink (input valid, input pixel, input frame_start, input frame_end,
                output ready);
endinterface

@@ hw/rtl/fnas_out_if.sv @@
// Interface: averaged pixel result channel.
interface fnas_out_if;
  logic                  valid;
  logic                  ready;
  logic [fnas_pkg::PIX_W-1:0] average;
  logic                  last_of_page;

  modport source (output valid, output average, output last_of_page, input ready);
  modport sink (input valid, input average, input last_of_page, output ready);
endinterface

@@ hw/rtl/fnas_ram.sv @@
// Generic simple dual-port RAM with registered read.
module fnas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/fnas_window.sv @@
// Window: line memory, fill tracking, tap history and eight-neighbour sum.
module fnas_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  fnas_pkg::pix_t      pixel,
  input  logic                frame_start,
  input  logic                frame_end,
  output fnas_pkg::res_t      res
);
  import fnas_pkg::*;

  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_base;
  logic              produce;

  logic              s1_v_r, s1_prod_r, s1_last_r;
  pix_t              s1_px_r;
  logic [PTR_W-1:0]  s1_ptr_r;

  pix_t              p1_r, p2_r, a1_r, a2_r, b1_r, b2_r;
  logic [2*PIX_W-1:0] rd_data;
  pix_t              tap_a, tap_b;
  logic [SUM_W-1:0]  sum;

  // entry holds {x[k], x[k-W]}; read for item n gives {x[n-W], x[n-2W]}
  fnas_ram #(.WIDTH(2 * PIX_W), .DEPTH(LINE_WIDTH)) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_v_r),
    .wr_addr (s1_ptr_r),
    .wr_data ({s1_px_r, tap_a}),
    .rd_en   (accept),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  assign tap_a = rd_data[2*PIX_W-1:PIX_W];
  assign tap_b = rd_data[PIX_W-1:0];

  always_comb begin
    fill_base = frame_start ? '0 : fill_r;
    produce   = (fill_base >= FILL_W'(LINE_DEPTH));
    fill_nxt  = produce ? fill_base : fill_base + FILL_W'(1);
    ptr_nxt   = (ptr_r == PTR_W'(LINE_WIDTH - 1)) ? '0 : ptr_r + PTR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      if (accept) begin
        ptr_r  <= ptr_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r <= produce;
      s1_last_r <= frame_end;
      s1_px_r   <= pixel;
      s1_ptr_r  <= ptr_r;
    end
    if (s1_v_r) begin
      p1_r <= s1_px_r;
      p2_r <= p1_r;
      a1_r <= tap_a;
      a2_r <= a1_r;
      b1_r <= tap_b;
      b2_r <= b1_r;
    end
  end

  always_comb begin
    sum = SUM_W'(s1_px_r) + SUM_W'(p1_r) + SUM_W'(p2_r) + SUM_W'(tap_a)
        + SUM_W'(a2_r) + SUM_W'(tap_b) + SUM_W'(b1_r) + SUM_W'(b2_r);
    res.valid        = s1_v_r && s1_prod_r;
    res.average      = sum[SUM_W-1:3];
    res.last_of_page = s1_last_r;
  end

endmodule

@@ hw/rtl/fnas_out_fifo.sv @@
// Output queue: small register FIFO that decouples results from the sink.
module fnas_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fnas_pkg::res_t             res,
  output logic [fnas_pkg::FIFO_CW-1:0] level,
  fnas_out_if.source                 out_ch
);
  import fnas_pkg::*;

  typedef struct packed {
    pix_t average;
    logic last_of_page;
  } entry_t;

  entry_t               buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                 pop;

  assign pop   = out_ch.valid && out_ch.ready;
  assign level = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res.valid && !pop) begin
      cnt_nxt = cnt_r + FIFO_CW'(1);
    end else if (!res.valid && pop) begin
      cnt_nxt = cnt_r - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res.valid) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      buf_r[wr_ptr_r] <= '{average: res.average, last_of_page: res.last_of_page};
    end
  end

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.average      = buf_r[rd_ptr_r].average;
  assign out_ch.last_of_page = buf_r[rd_ptr_r].last_of_page;

endmodule

@@ hw/rtl/fire_neighbour_average_scroll.sv @@
// Top level: eight-neighbour fire average with upward scroll.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------
//  in_ch    | in  | valid / ready  | pixel[7:0], frame_start, frame_end
//  out_ch   | out | valid / ready  | average[7:0], last_of_page
//
// One pixel per clock while in_ch.ready is high; a result passes through the stage-1 registers, then the output queue.
// Rate is set by the line RAM: one read at accept, one write in the following cycle.
// Reset clears the pointer, fill count and queue; the line RAM is not cleared.
// A 4-entry output queue absorbs stalls; in_ch.ready drops when it nears full.
module fire_neighbour_average_scroll (
  input  logic      clk,
  input  logic      rst_n,
  fnas_in_if.sink   in_ch,
  fnas_out_if.source out_ch
);
  import fnas_pkg::*;

  res_t               res;
  logic [FIFO_CW-1:0] level;
  logic               accept;

  assign in_ch.ready = ((FIFO_CW + 1)'(level) + (FIFO_CW + 1)'(res.valid))
                       <= (FIFO_CW + 1)'(FIFO_HEADROOM);
  assign accept      = in_ch.valid && in_ch.ready;

  fnas_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel       (in_ch.pixel),
    .frame_start (in_ch.frame_start),
    .frame_end   (in_ch.frame_end),
    .res         (res)
  );

  fnas_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .level  (level),
    .out_ch (out_ch)
  );

endmodule
